// ----- rtl/vdp_pkg.sv -----
// Shared types and constants for the host port of the video display processor.
package vdp_pkg;

  // Register slots the register file can hold: a six-bit register number
  localparam int unsigned REG_SLOTS = 64;

  // Width of the address formed by the command port before trimming to the VRAM size
  localparam int unsigned CMD_ADDR_BITS = 17;

  // Control registers with a fixed role in the host port
  localparam logic [5:0] REG_VRAM_HI    = 6'd14;  // VRAM address bits 16-14
  localparam logic [5:0] REG_STATUS_SEL = 6'd15;  // status register select
  localparam logic [5:0] REG_PAL_INDEX  = 6'd16;  // palette index
  localparam logic [5:0] REG_IND_SELECT = 6'd17;  // indirect register select

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PORT_DATA = 2'd0,
    PORT_CMD  = 2'd1,
    PORT_PAL  = 2'd2,
    PORT_IND  = 2'd3
  } port_e;

  typedef struct packed {
    op_e         opcode;
    port_e       port_select;
    logic [7:0]  data_byte;
    logic [7:0]  status_in;
  } vdp_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        reg_write_valid;
    logic [5:0]  reg_number;
    logic [7:0]  reg_value;
    logic        palette_write_valid;
    logic [3:0]  palette_entry;
    logic [8:0]  palette_color;
    logic [3:0]  status_number;
  } vdp_rsp_t;

  // Register file update for one request: one host write plus the two auto-increments
  typedef struct packed {
    logic        wr_en;
    logic [5:0]  wr_num;
    logic [7:0]  wr_value;
    logic        idx_en;
    logic [7:0]  idx_value;
    logic        sel_en;
    logic [7:0]  sel_value;
  } vdp_reg_upd_t;

  // Fixed read taps of the register file
  typedef struct packed {
    logic [7:0]  r14;
    logic [7:0]  r15;
    logic [7:0]  r16;
    logic [7:0]  r17;
  } vdp_reg_taps_t;

endpackage

// ----- rtl/vdp_stream_if.sv -----
// Valid/ready channel carrying one request or result payload.
interface vdp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/vdp_host_port_interface.sv -----
// Host port interface: decodes host port accesses into VRAM, register and palette updates.
//
// Each request is one host access (read or write to the data, command/status,
// palette or indirect-register port). The block takes one request per clock
// while the result side keeps up: a request is held in the input register,
// decoded out of it against the current port state, and its result lands in
// the output register, from which it is offered until it is taken.
// The result register parts the two sides: a new request is taken while a
// finished result still waits, and back-pressure on the result side stalls
// the decode stage only once the result register is full. The VRAM read-ahead
// byte comes from the video memory's registered read port; a data-port read
// or a read setup issues the prefetch in its decode cycle, and the byte is on
// the read port in time for the very next request. Video memory comes out of
// reset unwritten and needs no clearing pass; the control registers clear on
// reset. Palette entries are reported on the result only; the color RAM itself
// lives downstream.
module vdp_host_port_interface #(
  parameter int unsigned REGISTER_COUNT    = 47,
  parameter int unsigned VRAM_ADDRESS_BITS = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vdp_stream_if.sink    req_i,
  vdp_stream_if.source  rsp_o
);
  import vdp_pkg::*;

  localparam int unsigned AW         = VRAM_ADDRESS_BITS;
  localparam logic [6:0]  RegCountW  = 7'(REGISTER_COUNT);
  localparam bit          HasPalIdx  = REGISTER_COUNT > 16;
  localparam bit          HasIndSel  = REGISTER_COUNT > 17;
  localparam logic [AW-1:0] AddrOne  = AW'(1);

  // Input register
  logic     s1_valid_q;
  vdp_req_t s1_req_q;

  // Result register
  logic     out_valid_q;
  vdp_rsp_t out_rsp_q;
  vdp_rsp_t rsp_d;

  // Port state
  logic [AW-1:0] vram_addr_q, vram_addr_d;
  logic          cmd_full_q, cmd_full_d;
  logic [7:0]    cmd_byte_q, cmd_byte_d;
  logic          pal_full_q, pal_full_d;
  logic [7:0]    pal_byte_q, pal_byte_d;
  logic          ra_loaded_q;

  // Memory and register file hookup
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  logic [7:0]    read_ahead;
  vdp_reg_upd_t  reg_upd;
  vdp_reg_taps_t reg_taps;

  logic advance;

  // Decode advances when a request waits and the result register has room
  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;

  // Read-ahead is the last prefetched byte, zero until the first prefetch
  assign read_ahead = ra_loaded_q ? mem_rdata : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q <= req_i.payload;
    end
  end

  // Decode one request against the port state
  always_comb begin
    logic [CMD_ADDR_BITS-1:0] cmd_addr;
    logic [AW-1:0]            new_addr;
    logic [5:0]               ind_num;

    vram_addr_d = vram_addr_q;
    cmd_full_d  = cmd_full_q;
    cmd_byte_d  = cmd_byte_q;
    pal_full_d  = pal_full_q;
    pal_byte_d  = pal_byte_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = vram_addr_q;
    reg_upd     = '0;
    rsp_d       = '0;

    cmd_addr = {reg_taps.r14[2:0], s1_req_q.data_byte[5:0], cmd_byte_q};
    new_addr = cmd_addr[AW-1:0];
    ind_num  = reg_taps.r17[5:0];

    if (s1_req_q.opcode == OP_READ) begin
      unique case (s1_req_q.port_select)
        PORT_DATA: begin
          // Return the read-ahead byte and fetch the next one
          rsp_d.read_data = read_ahead;
          mem_re          = 1'b1;
          vram_addr_d     = vram_addr_q + AddrOne;
        end
        PORT_CMD: begin
          rsp_d.read_data = s1_req_q.status_in;
          cmd_full_d      = 1'b0;
        end
        PORT_PAL, PORT_IND: begin
          // Reads of these ports return zero
        end
        default: begin
        end
      endcase
    end else begin
      unique case (s1_req_q.port_select)
        PORT_DATA: begin
          mem_we      = 1'b1;
          vram_addr_d = vram_addr_q + AddrOne;
        end
        PORT_CMD: begin
          if (!cmd_full_q) begin
            cmd_byte_d = s1_req_q.data_byte;
            cmd_full_d = 1'b1;
          end else begin
            cmd_full_d = 1'b0;
            if (s1_req_q.data_byte[7]) begin
              // Register write: latched byte goes to the register named here
              if ({1'b0, s1_req_q.data_byte[5:0]} < RegCountW) begin
                reg_upd.wr_en    = 1'b1;
                reg_upd.wr_num   = s1_req_q.data_byte[5:0];
                reg_upd.wr_value = cmd_byte_q;
              end
            end else begin
              // Address setup; a read setup also prefetches
              vram_addr_d = new_addr;
              if (!s1_req_q.data_byte[6]) begin
                mem_re      = 1'b1;
                mem_addr    = new_addr;
                vram_addr_d = new_addr + AddrOne;
              end
            end
          end
        end
        PORT_PAL: begin
          if (!pal_full_q) begin
            pal_byte_d = s1_req_q.data_byte;
            pal_full_d = 1'b1;
          end else begin
            pal_full_d                = 1'b0;
            rsp_d.palette_write_valid = 1'b1;
            rsp_d.palette_entry       = reg_taps.r16[3:0];
            rsp_d.palette_color       = {pal_byte_q[6:4], s1_req_q.data_byte[2:0],
                                         pal_byte_q[2:0]};
            // Step the palette index
            reg_upd.idx_en    = HasPalIdx;
            reg_upd.idx_value = {4'h0, reg_taps.r16[3:0] + 4'd1};
          end
        end
        PORT_IND: begin
          if (ind_num != REG_IND_SELECT && {1'b0, ind_num} < RegCountW) begin
            reg_upd.wr_en    = 1'b1;
            reg_upd.wr_num   = ind_num;
            reg_upd.wr_value = s1_req_q.data_byte;
          end
          // Auto-increment the indirect select unless it is held
          reg_upd.sel_en    = HasIndSel && !reg_taps.r17[7];
          reg_upd.sel_value = {reg_taps.r17[7:6], ind_num + 6'd1};
        end
        default: begin
        end
      endcase
    end

    // A write to the palette index drops any half-written palette entry
    if (reg_upd.wr_en && reg_upd.wr_num == REG_PAL_INDEX) begin
      pal_full_d = 1'b0;
    end

    rsp_d.reg_write_valid = reg_upd.wr_en;
    rsp_d.reg_number      = reg_upd.wr_num;
    rsp_d.reg_value       = reg_upd.wr_value;
    rsp_d.status_number   = (reg_upd.wr_en && reg_upd.wr_num == REG_STATUS_SEL)
                          ? reg_upd.wr_value[3:0] : reg_taps.r15[3:0];

    // Nothing takes effect unless the request advances
    if (!advance) begin
      mem_we  = 1'b0;
      mem_re  = 1'b0;
      reg_upd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vram_addr_q <= '0;
      cmd_full_q  <= 1'b0;
      cmd_byte_q  <= '0;
      pal_full_q  <= 1'b0;
      pal_byte_q  <= '0;
      ra_loaded_q <= 1'b0;
    end else if (advance) begin
      vram_addr_q <= vram_addr_d;
      cmd_full_q  <= cmd_full_d;
      cmd_byte_q  <= cmd_byte_d;
      pal_full_q  <= pal_full_d;
      pal_byte_q  <= pal_byte_d;
      if (mem_re) begin
        ra_loaded_q <= 1'b1;
      end
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_rsp_q;

  vdp_vram #(
    .VRAM_ADDRESS_BITS(VRAM_ADDRESS_BITS)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(s1_req_q.data_byte),
    .rdata_o(mem_rdata)
  );

  vdp_ctrl_regs #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_ctrl_regs (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .upd_i (reg_upd),
    .taps_o(reg_taps)
  );

`ifndef NO_ASSERTIONS
  // One request never both writes and reads video memory
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && mem_re))
    else $error("VRAM read and write in the same cycle");

  // A decoded request always leaves a result in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni) advance |=> out_valid_q)
    else $error("decoded request lost its result");

  // Reported register writes only name implemented registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_rsp_q.reg_write_valid |-> {1'b0, out_rsp_q.reg_number} < RegCountW)
    else $error("register write beyond register count");

  // A single access never completes a palette entry and writes a register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> !(out_rsp_q.reg_write_valid && out_rsp_q.palette_write_valid))
    else $error("palette and register write in one result");
`endif
endmodule

// ----- rtl/vdp_vram.sv -----
// Video memory: one write or one registered read per cycle.
module vdp_vram #(
  parameter int unsigned VRAM_ADDRESS_BITS = 17
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [VRAM_ADDRESS_BITS-1:0] addr_i,
  input  logic [7:0]                   wdata_i,
  output logic [7:0]                   rdata_o
);
  localparam int unsigned Depth = 2 ** VRAM_ADDRESS_BITS;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Hold the last read until the next one
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/vdp_ctrl_regs.sv -----
// Control register file with reset-cleared registers and fixed read taps.
module vdp_ctrl_regs #(
  parameter int unsigned REGISTER_COUNT = 47
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vdp_pkg::vdp_reg_upd_t  upd_i,
  output vdp_pkg::vdp_reg_taps_t taps_o
);
  import vdp_pkg::*;

  logic [7:0] regs_q [REG_SLOTS];

  // Slots at or above the register count stay at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_SLOTS; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < REG_SLOTS; i++) begin
        if (i < REGISTER_COUNT) begin
          if (upd_i.wr_en && upd_i.wr_num == 6'(i)) begin
            regs_q[i] <= upd_i.wr_value;
          end else if (upd_i.idx_en && 6'(i) == REG_PAL_INDEX) begin
            regs_q[i] <= upd_i.idx_value;
          end else if (upd_i.sel_en && 6'(i) == REG_IND_SELECT) begin
            regs_q[i] <= upd_i.sel_value;
          end
        end
      end
    end
  end

  assign taps_o.r14 = regs_q[REG_VRAM_HI];
  assign taps_o.r15 = regs_q[REG_STATUS_SEL];
  assign taps_o.r16 = regs_q[REG_PAL_INDEX];
  assign taps_o.r17 = regs_q[REG_IND_SELECT];
endmodule

// ----- verif/vdp_host_port_interface_tb.sv -----
// Self-checking testbench for the host port interface of the video display processor.
`timescale 1ns / 1ps

module vdp_host_port_interface_tb;
  import vdp_pkg::*;

  localparam int unsigned REGISTER_COUNT    = 47;
  localparam int unsigned VRAM_ADDRESS_BITS = 17;
  localparam int unsigned RANDOM_ITEMS      = 1800;

  typedef logic [VRAM_ADDRESS_BITS-1:0] vram_addr_t;

  // One stretch of VRAM that a write burst filled, kept for later read bursts
  typedef struct {
    vram_addr_t  start;
    int unsigned len;
  } vram_run_t;

  // Shadow of the port state plus the results still awaited from the block.
  class port_state_tracker;
    logic [7:0]       regs [REG_SLOTS];
    logic [7:0]       vram [int unsigned];  // only written locations exist
    vram_addr_t       vram_addr;
    bit               cmd_full;
    logic [7:0]       cmd_byte;
    logic [7:0]       read_ahead;
    bit               pal_full;
    logic [7:0]       pal_byte;
    logic [8:0]       palette [16];
    vdp_rsp_t         awaited [$];
    int               errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (palette[i]) palette[i] = '0;
      vram_addr  = '0;
      cmd_full   = 1'b0;
      cmd_byte   = '0;
      read_ahead = '0;
      pal_full   = 1'b0;
      pal_byte   = '0;
      errors     = 0;
    endfunction

    function void fetch_ahead();
      read_ahead = vram[vram_addr];
      vram_addr  = vram_addr + 1'b1;
    endfunction

    function bit store_register(logic [5:0] num, logic [7:0] value);
      if (num >= REGISTER_COUNT) return 1'b0;
      regs[num] = value;
      if (num == REG_PAL_INDEX) pal_full = 1'b0;
      return 1'b1;
    endfunction

    // Steer a request away from reading VRAM that was never written.
    function vdp_req_t keep_reads_defined(vdp_req_t rq);
      logic [CMD_ADDR_BITS-1:0] full_addr;
      vram_addr_t               target;
      if (rq.opcode == OP_READ && rq.port_select == PORT_DATA && !vram.exists(vram_addr))
        rq.opcode = OP_WRITE;
      if (rq.opcode == OP_WRITE && rq.port_select == PORT_CMD && cmd_full &&
          !rq.data_byte[7] && !rq.data_byte[6]) begin
        full_addr = {regs[REG_VRAM_HI][2:0], rq.data_byte[5:0], cmd_byte};
        target    = full_addr[VRAM_ADDRESS_BITS-1:0];
        if (!vram.exists(target)) rq.data_byte[6] = 1'b1;  // turn into a write setup
      end
      return rq;
    endfunction

    // Apply one accepted request to the shadow state and queue its result.
    function void note_request(vdp_req_t rq);
      vdp_rsp_t                 want;
      logic [7:0]               sel;
      logic [5:0]               num;
      logic [3:0]               idx;
      logic [CMD_ADDR_BITS-1:0] full_addr;
      want = '0;
      if (rq.opcode == OP_READ) begin
        if (rq.port_select == PORT_DATA) begin
          want.read_data = read_ahead;
          fetch_ahead();
        end else if (rq.port_select == PORT_CMD) begin
          want.read_data = rq.status_in;
          cmd_full = 1'b0;
        end
      end else begin
        case (rq.port_select)
          PORT_DATA: begin
            vram[vram_addr] = rq.data_byte;
            vram_addr = vram_addr + 1'b1;
          end
          PORT_CMD: begin
            if (!cmd_full) begin
              cmd_byte = rq.data_byte;
              cmd_full = 1'b1;
            end else begin
              cmd_full = 1'b0;
              if (rq.data_byte[7]) begin
                if (store_register(rq.data_byte[5:0], cmd_byte)) begin
                  want.reg_write_valid = 1'b1;
                  want.reg_number      = rq.data_byte[5:0];
                  want.reg_value       = cmd_byte;
                end
              end else begin
                full_addr = {regs[REG_VRAM_HI][2:0], rq.data_byte[5:0], cmd_byte};
                vram_addr = full_addr[VRAM_ADDRESS_BITS-1:0];
                if (!rq.data_byte[6]) fetch_ahead();
              end
            end
          end
          PORT_PAL: begin
            if (!pal_full) begin
              pal_byte = rq.data_byte;
              pal_full = 1'b1;
            end else begin
              idx = regs[REG_PAL_INDEX][3:0];
              pal_full = 1'b0;
              want.palette_color       = {pal_byte[6:4], rq.data_byte[2:0], pal_byte[2:0]};
              want.palette_write_valid = 1'b1;
              want.palette_entry       = idx;
              palette[idx] = want.palette_color;
              if (REG_PAL_INDEX < REGISTER_COUNT) regs[REG_PAL_INDEX] = {4'd0, idx + 4'd1};
            end
          end
          PORT_IND: begin
            sel = regs[REG_IND_SELECT];
            num = sel[5:0];
            if (num != REG_IND_SELECT && store_register(num, rq.data_byte)) begin
              want.reg_write_valid = 1'b1;
              want.reg_number      = num;
              want.reg_value       = rq.data_byte;
            end
            if (!sel[7] && REG_IND_SELECT < REGISTER_COUNT)
              regs[REG_IND_SELECT] = {sel[7:6], num + 6'd1};
          end
        endcase
      end
      want.status_number = regs[REG_STATUS_SEL][3:0];
      awaited.push_back(want);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("@%0t: %s expected 'h%0h, actual 'h%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(vdp_rsp_t got);
      vdp_rsp_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("@%0t: result expected none, actual 'h%0h", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("reg_write_valid", want.reg_write_valid, got.reg_write_valid);
      compare_field("reg_number", want.reg_number, got.reg_number);
      compare_field("reg_value", want.reg_value, got.reg_value);
      compare_field("palette_write_valid", want.palette_write_valid, got.palette_write_valid);
      compare_field("palette_entry", want.palette_entry, got.palette_entry);
      compare_field("palette_color", want.palette_color, got.palette_color);
      compare_field("status_number", want.status_number, got.status_number);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_off;
  int   items_sent = 0;

  port_state_tracker sb = new();
  vram_run_t         written_runs [$];

  vdp_stream_if #(.T(vdp_req_t)) req_if ();
  vdp_stream_if #(.T(vdp_rsp_t)) rsp_if ();

  vdp_host_port_interface #(
    .REGISTER_COUNT    (REGISTER_COUNT),
    .VRAM_ADDRESS_BITS (VRAM_ADDRESS_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Idle length for either side: mostly a few cycles, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offer one request, holding valid until the block takes it, then record it.
  // Valid stays high across back-to-back requests so it never toggles in one step.
  task automatic send_request(input op_e op, input port_e port,
                              input logic [7:0] data, input logic [7:0] status);
    vdp_req_t rq;
    int       gap;
    rq.opcode      = op;
    rq.port_select = port;
    rq.data_byte   = data;
    rq.status_in   = status;
    rq = sb.keep_reads_defined(rq);
    // Keep calm stretches with no gaps, and never idle while the receiver holds off.
    gap = (hold_off || (items_sent % 500) < 120 || $urandom_range(0, 99) < 55) ?
          0 : idle_length();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(rq);
    items_sent++;
  endtask

  // Send a command-port byte pair; drop a half-filled latch first with a status read.
  task automatic write_cmd_pair(input logic [7:0] first, input logic [7:0] second);
    if (sb.cmd_full) send_request(OP_READ, PORT_CMD, 8'($urandom), 8'($urandom));
    send_request(OP_WRITE, PORT_CMD, first, 8'($urandom));
    send_request(OP_WRITE, PORT_CMD, second, 8'($urandom));
  endtask

  task automatic host_set_register(input logic [5:0] num, input logic [7:0] value);
    write_cmd_pair(value, {1'b1, 1'($urandom), num});
  endtask

  // Main stimulus: reset, a directed walk through the ports, then random sequences.
  initial begin
    int          n;
    int          pick;
    logic [5:0]  num;
    logic [7:0]  sel;
    vram_run_t   run;

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Status reads at both extremes, R#15 to its top value, an out-of-range register
    send_request(OP_READ, PORT_CMD, 8'h00, 8'hFF);
    write_cmd_pair(8'h0F, 8'h8F);
    send_request(OP_READ, PORT_CMD, 8'hFF, 8'h00);
    write_cmd_pair(8'h55, 8'hBF);
    // Top VRAM address, wrap to zero, then a read setup back at the top
    write_cmd_pair(8'h07, 8'h8E);
    write_cmd_pair(8'hFF, 8'h7F);
    send_request(OP_WRITE, PORT_DATA, 8'hA5, 8'($urandom));
    send_request(OP_WRITE, PORT_DATA, 8'h5A, 8'($urandom));
    send_request(OP_WRITE, PORT_DATA, 8'h00, 8'($urandom));
    write_cmd_pair(8'hFF, 8'h3F);
    send_request(OP_READ, PORT_DATA, 8'hFF, 8'($urandom));
    send_request(OP_READ, PORT_DATA, 8'h00, 8'($urandom));
    // Full palette entry, then a half entry dropped by an R#16 write
    send_request(OP_WRITE, PORT_PAL, 8'hFF, 8'($urandom));
    send_request(OP_WRITE, PORT_PAL, 8'hFF, 8'($urandom));
    send_request(OP_WRITE, PORT_PAL, 8'h00, 8'($urandom));
    write_cmd_pair(8'h0F, 8'h90);
    send_request(OP_WRITE, PORT_PAL, 8'h70, 8'($urandom));
    send_request(OP_WRITE, PORT_PAL, 8'h07, 8'($urandom));
    // Indirect select at 63 wraps to 0; with bit 7 set it holds on R#16
    write_cmd_pair(8'h3F, 8'h91);
    send_request(OP_WRITE, PORT_IND, 8'hAA, 8'($urandom));
    write_cmd_pair(8'h90, 8'h91);
    send_request(OP_WRITE, PORT_IND, 8'h44, 8'($urandom));

    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        // Register write, biased toward the registers with a role in the port
        pick = $urandom_range(0, 9);
        if (pick < 3) num = REG_VRAM_HI + 6'($urandom_range(0, 3));
        else if (pick < 8) num = 6'($urandom_range(0, REGISTER_COUNT - 1));
        else num = 6'($urandom_range(REGISTER_COUNT, REG_SLOTS - 1));
        host_set_register(num, 8'($urandom));
      end else if (pick < 40) begin
        // Write setup at a random address and a burst of data writes
        if ($urandom_range(0, 1)) host_set_register(REG_VRAM_HI, 8'($urandom));
        write_cmd_pair(8'($urandom), {2'b01, 6'($urandom)});
        run.start = sb.vram_addr;
        run.len   = $urandom_range(1, 8);
        for (int i = 0; i < run.len; i++)
          send_request(OP_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
        written_runs.push_back(run);
        if (written_runs.size() > 64) void'(written_runs.pop_front());
      end else if (pick < 60 && written_runs.size() != 0) begin
        // Read setup on a filled stretch and read it back, maybe one past its end
        run = written_runs[$urandom_range(0, written_runs.size() - 1)];
        host_set_register(REG_VRAM_HI, {5'($urandom), run.start[16:14]});
        write_cmd_pair(run.start[7:0], {2'b00, run.start[13:8]});
        n = $urandom_range(1, run.len + 1);
        for (int i = 0; i < n; i++)
          send_request(OP_READ, PORT_DATA, 8'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        // Palette bytes, now and then moving the index mid-entry
        if ($urandom_range(0, 3) == 0) host_set_register(REG_PAL_INDEX, 8'($urandom));
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) host_set_register(REG_PAL_INDEX, 8'($urandom));
          send_request(OP_WRITE, PORT_PAL, 8'($urandom), 8'($urandom));
        end
      end else if (pick < 90) begin
        // Indirect writes from a select near the interesting corners
        case ($urandom_range(0, 3))
          0:       sel = 8'($urandom);
          1:       sel = {2'($urandom), REG_IND_SELECT};
          2:       sel = {2'($urandom), 6'($urandom_range(REGISTER_COUNT - 3, REG_SLOTS - 1))};
          default: sel = {1'b0, 1'($urandom), 6'($urandom_range(0, 20))};
        endcase
        host_set_register(REG_IND_SELECT, sel);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_request(OP_WRITE, PORT_IND, 8'($urandom), 8'($urandom));
      end else begin
        // Noise: any request on any port, including broken byte pairs
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_request(op_e'($urandom_range(0, 1)), port_e'($urandom_range(0, 3)),
                       8'($urandom), 8'($urandom));
      end
    end

    req_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    // Allow for any stray result beyond the awaited ones
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("vdp_host_port_interface: match");
    end else begin
      $display("vdp_host_port_interface: mismatch");
    end
    $finish;
  end

  // Result side: check every accepted result and stall ready at random.
  initial begin
    int          stall_left;
    int unsigned cycle_no;
    stall_left   = 0;
    cycle_no     = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_no++;
      if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        // Leave calm stretches where ready stays high
        if ((cycle_no % 3000) >= 600 && $urandom_range(0, 99) < 25)
          stall_left = idle_length();
      end
    end
  end

  // Hold the result side off for a long stretch so the block fills and stalls requests.
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= 700);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog: end the run if the block stops answering.
  initial begin
    #(10_000_000);
    $display("vdp_host_port_interface: mismatch");
    $finish;
  end

endmodule
